// ----- rtl/bpc_pkg.sv -----
// Package with shared types and constants of the button press classifier.
`timescale 1ns / 1ps
`default_nettype none

package bpc_pkg;

  // Widths of tick counters, series counters and the register index.
  localparam int unsigned TickW  = 10;
  localparam int unsigned CountW = 8;
  localparam int unsigned IndexW = 3;

  // Largest tick count that fits the counter width.
  localparam logic [TickW-1:0] TickMax = '1;

  // Register indexes of the configuration port.
  typedef enum logic [IndexW-1:0] {
    REG_LONG_PRESS_TICKS = 3'd0,
    REG_COUNT_CAP        = 3'd1,
    REG_DOUBLE_WINDOW    = 3'd2,
    REG_DOUBLE_HOLD      = 3'd3,
    REG_SHORT_SERIES_GAP = 3'd4,
    REG_LONG_SERIES_GAP  = 3'd5
  } reg_index_t;

  // Reset values of the configuration registers.
  localparam logic [TickW-1:0] LongPressTicksReset = 10'd200;
  localparam logic [TickW-1:0] CountCapReset       = 10'd1000;
  localparam logic [TickW-1:0] DoubleWindowReset   = 10'd50;
  localparam logic [TickW-1:0] DoubleHoldReset     = 10'd10;
  localparam logic [TickW-1:0] ShortSeriesGapReset = 10'd200;
  localparam logic [TickW-1:0] LongSeriesGapReset  = 10'd600;

  // Current configuration as seen by the classifier core.
  typedef struct packed {
    logic [TickW-1:0] long_press_ticks;
    logic [TickW-1:0] count_cap;
    logic [TickW-1:0] double_window;
    logic [TickW-1:0] double_hold;
    logic [TickW-1:0] short_series_gap;
    logic [TickW-1:0] long_series_gap;
  } cfg_t;

  // One result transaction.
  typedef struct packed {
    logic              long_held;
    logic              short_held;
    logic              short_release;
    logic              long_release;
    logic              double_click;
    logic [CountW-1:0] short_series;
    logic [CountW-1:0] long_series;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/button_press_classifier.sv -----
// Top level of the button press classifier: handshake, core and output register.
// Takes one sampled button level per input transaction and returns one result
// transaction for each. A sample is accepted every clock cycle as long as the
// output register is empty or being drained; the result is registered in the
// next cycle, set by the single state update between the input handshake and
// the output register. Configuration registers are written through a plain
// write port and should only be changed while no transaction is in flight.
`timescale 1ns / 1ps
`default_nettype none

module button_press_classifier
  import bpc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_write,
  input  wire logic [IndexW-1:0] cfg_index,
  input  wire logic [TickW-1:0]  cfg_data,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              pressed,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   long_held,
  output logic                   short_held,
  output logic                   short_release,
  output logic                   long_release,
  output logic                   double_click,
  output logic [CountW-1:0]      short_series,
  output logic [CountW-1:0]      long_series
);

  cfg_t    cfg;
  result_t result;
  result_t out_reg;
  logic    accept;

  bpc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bpc_core u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (accept),
    .pressed (pressed),
    .cfg     (cfg),
    .result  (result)
  );

  // Stall input only while a finished result is held and not taken.
  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload register loads with each accepted transaction.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_reg <= result;
    end
  end

  assign long_held     = out_reg.long_held;
  assign short_held    = out_reg.short_held;
  assign short_release = out_reg.short_release;
  assign long_release  = out_reg.long_release;
  assign double_click  = out_reg.double_click;
  assign short_series  = out_reg.short_series;
  assign long_series   = out_reg.long_series;

endmodule

`default_nettype wire

// ----- rtl/bpc_cfg.sv -----
// Configuration register file of the button press classifier.
`timescale 1ns / 1ps
`default_nettype none

module bpc_cfg
  import bpc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_write,
  input  wire logic [IndexW-1:0] cfg_index,
  input  wire logic [TickW-1:0]  cfg_data,
  output cfg_t                   cfg
);

  cfg_t regs;

  // Write one register per enabled cycle; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.long_press_ticks <= LongPressTicksReset;
      regs.count_cap        <= CountCapReset;
      regs.double_window    <= DoubleWindowReset;
      regs.double_hold      <= DoubleHoldReset;
      regs.short_series_gap <= ShortSeriesGapReset;
      regs.long_series_gap  <= LongSeriesGapReset;
    end else if (cfg_write) begin
      unique case (reg_index_t'(cfg_index))
        REG_LONG_PRESS_TICKS: regs.long_press_ticks <= cfg_data;
        REG_COUNT_CAP:        regs.count_cap        <= cfg_data;
        REG_DOUBLE_WINDOW:    regs.double_window    <= cfg_data;
        REG_DOUBLE_HOLD:      regs.double_hold      <= cfg_data;
        REG_SHORT_SERIES_GAP: regs.short_series_gap <= cfg_data;
        REG_LONG_SERIES_GAP:  regs.long_series_gap  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

`default_nettype wire

// ----- rtl/bpc_core.sv -----
// Classifier state and its combinational update for one button sample.
`timescale 1ns / 1ps
`default_nettype none

module bpc_core
  import bpc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic step,
  input  wire logic pressed,
  input  wire cfg_t cfg,
  output result_t   result
);

  logic [TickW-1:0]  press_ticks, press_ticks_next;
  logic [TickW-1:0]  release_ticks, release_ticks_next;
  logic [TickW-1:0]  since_short, since_short_next;
  logic              long_flag, long_flag_next;
  logic              short_flag, short_flag_next;
  logic              double_flag, double_flag_next;
  logic [CountW-1:0] short_count, short_count_next;
  logic [CountW-1:0] long_count, long_count_next;
  logic              short_pulse, long_pulse;

  // Next state for one sample.
  always_comb begin
    press_ticks_next   = press_ticks;
    release_ticks_next = release_ticks;
    since_short_next   = since_short;
    long_flag_next     = long_flag;
    short_flag_next    = short_flag;
    double_flag_next   = double_flag;
    short_count_next   = short_count;
    long_count_next    = long_count;
    short_pulse        = 1'b0;
    long_pulse         = 1'b0;

    // Press and release tick counting with the held flags and release pulses.
    if (pressed) begin
      release_ticks_next = '0;
      if (press_ticks < cfg.count_cap) begin
        press_ticks_next = press_ticks + 1'b1;
      end
      if (press_ticks_next > cfg.long_press_ticks) begin
        long_flag_next = 1'b1;
      end else if (press_ticks_next != '0 &&
                   press_ticks_next < cfg.long_press_ticks) begin
        short_flag_next = 1'b1;
      end
    end else begin
      long_flag_next  = 1'b0;
      short_flag_next = 1'b0;
      if (press_ticks > cfg.long_press_ticks) begin
        long_pulse = 1'b1;
      end else if (press_ticks != '0 && press_ticks < cfg.long_press_ticks) begin
        short_pulse = 1'b1;
      end
      press_ticks_next = '0;
      if (release_ticks < cfg.count_cap) begin
        release_ticks_next = release_ticks + 1'b1;
      end
    end

    // Short series count, double-click flag and the gap since the last short release.
    if (short_pulse) begin
      short_count_next = short_count + 1'b1;
      if (since_short <= cfg.double_window) begin
        double_flag_next = 1'b1;
      end
      since_short_next = TickW'(1);
    end else begin
      if (since_short <= cfg.count_cap && since_short != TickMax) begin
        since_short_next = since_short + 1'b1;
      end
      if (since_short_next >= cfg.double_hold) begin
        double_flag_next = 1'b0;
      end
    end
    if (release_ticks_next > cfg.short_series_gap) begin
      short_count_next = '0;
    end

    // Long series count.
    if (long_pulse) begin
      long_count_next = long_count + 1'b1;
    end
    if (release_ticks_next > cfg.long_series_gap) begin
      long_count_next = '0;
    end
  end

  // State registers advance once per accepted sample.
  always_ff @(posedge clk) begin
    if (rst) begin
      press_ticks   <= '0;
      release_ticks <= '0;
      since_short   <= '0;
      long_flag     <= 1'b0;
      short_flag    <= 1'b0;
      double_flag   <= 1'b0;
      short_count   <= '0;
      long_count    <= '0;
    end else if (step) begin
      press_ticks   <= press_ticks_next;
      release_ticks <= release_ticks_next;
      since_short   <= since_short_next;
      long_flag     <= long_flag_next;
      short_flag    <= short_flag_next;
      double_flag   <= double_flag_next;
      short_count   <= short_count_next;
      long_count    <= long_count_next;
    end
  end

  // Result fields are taken after the update.
  always_comb begin
    result.long_held     = long_flag_next;
    result.short_held    = short_flag_next;
    result.short_release = short_pulse;
    result.long_release  = long_pulse;
    result.double_click  = double_flag_next;
    result.short_series  = short_count_next;
    result.long_series   = long_count_next;
  end

endmodule

`default_nettype wire

// ----- dv/button_press_classifier_checker.sv -----
// Checker of the button press classifier: predicts every result transaction and compares it.
`timescale 1ns / 1ps

module button_press_classifier_checker
  import bpc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [IndexW-1:0] cfg_index,
  input  logic [TickW-1:0]  cfg_data,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic              pressed,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic              long_held,
  input  logic              short_held,
  input  logic              short_release,
  input  logic              long_release,
  input  logic              double_click,
  input  logic [CountW-1:0] short_series,
  input  logic [CountW-1:0] long_series,
  output int                mismatches,
  output int                pending
);

  localparam int ReportLimit = 10;

  // Local copy of the settings and of the classifier state.
  cfg_t              settings;
  logic [TickW-1:0]  held_ticks;
  logic [TickW-1:0]  idle_ticks;
  logic [TickW-1:0]  ticks_since_short;
  logic              long_flag;
  logic              short_flag;
  logic              double_flag;
  logic [CountW-1:0] short_run;
  logic [CountW-1:0] long_run;

  result_t predicted_results[$];
  int      fail_count = 0;
  int      waiting = 0;

  assign mismatches = fail_count;
  assign pending    = waiting;

  function automatic string describe(result_t r);
    return $sformatf({"long_held=%0b short_held=%0b short_release=%0b long_release=%0b ",
                      "double_click=%0b short_series=%0d long_series=%0d"},
                     r.long_held, r.short_held, r.short_release, r.long_release,
                     r.double_click, r.short_series, r.long_series);
  endfunction

  // Advances the local state by one button sample and gives the result it causes.
  task automatic classify_sample(input logic level, output result_t res);
    logic short_end;
    logic long_end;
    short_end = 1'b0;
    long_end  = 1'b0;
    if (level) begin
      idle_ticks = '0;
      if (held_ticks < settings.count_cap) held_ticks = held_ticks + 1'b1;
      if (held_ticks > settings.long_press_ticks) begin
        long_flag = 1'b1;
      end else if (held_ticks != '0 && held_ticks < settings.long_press_ticks) begin
        short_flag = 1'b1;
      end
    end else begin
      long_flag  = 1'b0;
      short_flag = 1'b0;
      if (held_ticks > settings.long_press_ticks) begin
        long_end = 1'b1;
      end else if (held_ticks != '0 && held_ticks < settings.long_press_ticks) begin
        short_end = 1'b1;
      end
      held_ticks = '0;
      if (idle_ticks < settings.count_cap) idle_ticks = idle_ticks + 1'b1;
    end

    // A short release restarts the double click window; otherwise the window ages.
    if (short_end) begin
      short_run = short_run + 1'b1;
      if (ticks_since_short <= settings.double_window) double_flag = 1'b1;
      ticks_since_short = TickW'(1);
    end else begin
      if (ticks_since_short <= settings.count_cap && ticks_since_short != TickMax) begin
        ticks_since_short = ticks_since_short + 1'b1;
      end
      if (ticks_since_short >= settings.double_hold) double_flag = 1'b0;
    end

    // Series counts clear after a long enough release gap.
    if (idle_ticks > settings.short_series_gap) short_run = '0;
    if (long_end) long_run = long_run + 1'b1;
    if (idle_ticks > settings.long_series_gap) long_run = '0;

    res.long_held     = long_flag;
    res.short_held    = short_flag;
    res.short_release = short_end;
    res.long_release  = long_end;
    res.double_click  = double_flag;
    res.short_series  = short_run;
    res.long_series   = long_run;
  endtask

  always @(posedge clk) begin
    result_t seen;
    result_t want;
    if (rst) begin
      settings.long_press_ticks = LongPressTicksReset;
      settings.count_cap        = CountCapReset;
      settings.double_window    = DoubleWindowReset;
      settings.double_hold      = DoubleHoldReset;
      settings.short_series_gap = ShortSeriesGapReset;
      settings.long_series_gap  = LongSeriesGapReset;
      held_ticks        = '0;
      idle_ticks        = '0;
      ticks_since_short = '0;
      long_flag         = 1'b0;
      short_flag        = 1'b0;
      double_flag       = 1'b0;
      short_run         = '0;
      long_run          = '0;
      predicted_results.delete();
      waiting <= 0;
    end else begin
      // Register writes; indexes past the list are ignored.
      if (cfg_write) begin
        case (cfg_index)
          REG_LONG_PRESS_TICKS: settings.long_press_ticks = cfg_data;
          REG_COUNT_CAP:        settings.count_cap        = cfg_data;
          REG_DOUBLE_WINDOW:    settings.double_window    = cfg_data;
          REG_DOUBLE_HOLD:      settings.double_hold      = cfg_data;
          REG_SHORT_SERIES_GAP: settings.short_series_gap = cfg_data;
          REG_LONG_SERIES_GAP:  settings.long_series_gap  = cfg_data;
          default: ;
        endcase
      end

      // Compare an accepted result transaction with the oldest prediction.
      if (out_valid && !out_stall) begin
        seen.long_held     = long_held;
        seen.short_held    = short_held;
        seen.short_release = short_release;
        seen.long_release  = long_release;
        seen.double_click  = double_click;
        seen.short_series  = short_series;
        seen.long_series   = long_series;
        if (predicted_results.size() == 0) begin
          if (fail_count < ReportLimit) begin
            $display("ERROR %0t: result with nothing predicted: %s", $time, describe(seen));
          end
          fail_count++;
        end else begin
          want = predicted_results.pop_front();
          if (seen !== want) begin
            if (fail_count < ReportLimit) begin
              $display("ERROR %0t: expected %s", $time, describe(want));
              $display("ERROR %0t: actual   %s", $time, describe(seen));
            end
            fail_count++;
          end
        end
      end

      // Predict the result of an accepted input transaction.
      if (in_valid && !in_stall) begin
        classify_sample(pressed, want);
        predicted_results.push_back(want);
      end
      waiting <= predicted_results.size();
    end
  end

endmodule

// ----- dv/button_press_classifier_tb.sv -----
// Testbench top of the button press classifier: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module button_press_classifier_tb;
  import bpc_pkg::*;

  localparam int HoldOffCycles = 300;
  localparam int CycleLimit    = 200000;
  localparam int SettleCycles  = 10;
  localparam logic [IndexW-1:0] SpareIndexLo = 3'd6;
  localparam logic [IndexW-1:0] SpareIndexHi = 3'd7;

  logic              clk;
  logic              rst;
  logic              cfg_write;
  logic [IndexW-1:0] cfg_index;
  logic [TickW-1:0]  cfg_data;
  logic              in_valid;
  logic              in_stall;
  logic              pressed;
  logic              out_valid;
  logic              out_stall;
  logic              long_held;
  logic              short_held;
  logic              short_release;
  logic              long_release;
  logic              double_click;
  logic [CountW-1:0] short_series;
  logic [CountW-1:0] long_series;
  int                mismatches;
  int                pending;

  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   hold_off_requests = 0;
  int   cycle_count = 0;
  cfg_t active_cfg;

  button_press_classifier dut (.*);

  button_press_classifier_checker classifier_check (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Guard against a hung handshake.
  initial begin
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CycleLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Receiver: random stalls, or a long hold-off each time one is requested.
  initial begin
    int served;
    int hold_left;
    served    = 0;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && served != hold_off_requests) begin
        served++;
        hold_left = HoldOffCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  function automatic cfg_t make_config(int press_limit, int cap, int window, int hold,
                                       int short_gap, int long_gap);
    cfg_t c;
    c.long_press_ticks = TickW'(press_limit);
    c.count_cap        = TickW'(cap);
    c.double_window    = TickW'(window);
    c.double_hold      = TickW'(hold);
    c.short_series_gap = TickW'(short_gap);
    c.long_series_gap  = TickW'(long_gap);
    return c;
  endfunction

  function automatic cfg_t random_config();
    return make_config($urandom_range(1, 12), $urandom_range(1, 30), $urandom_range(0, 15),
                       $urandom_range(0, 15), $urandom_range(0, 20), $urandom_range(0, 30));
  endfunction

  // Press lengths cluster around the threshold and the counter cap.
  function automatic int press_length();
    int thr;
    thr = int'(active_cfg.long_press_ticks);
    case ($urandom_range(0, 7))
      0: return 1;
      1: return (thr > 1) ? thr - 1 : 1;
      2: return (thr > 0) ? thr : 1;
      3: return thr + 1;
      4: return thr + int'($urandom_range(2, 6));
      5: return int'(active_cfg.count_cap) + int'($urandom_range(1, 3));
      default: return int'($urandom_range(1, 2 * thr + 2));
    endcase
  endfunction

  // Release lengths cluster around the window, hold and series gaps and the counter cap.
  function automatic int gap_length();
    case ($urandom_range(0, 11))
      0: return 1;
      1: return int'(active_cfg.double_window) + 1;
      2: return int'(active_cfg.double_hold) + 1;
      3: return int'(active_cfg.short_series_gap);
      4: return int'(active_cfg.short_series_gap) + 1;
      5: return int'(active_cfg.long_series_gap);
      6: return int'(active_cfg.long_series_gap) + 1;
      7: return int'(active_cfg.count_cap) + 2;
      default: return int'($urandom_range(1, 6));
    endcase
  endfunction

  // Offers one sample and returns at the edge where the transaction is accepted.
  task automatic send_sample(input logic level);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    pressed  <= level;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_run(input logic level, input int len, inout int budget);
    for (int i = 0; i < len && budget > 0; i++) begin
      send_sample(level);
      budget--;
    end
  endtask

  // Stops offering and waits until every predicted result has come back.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_register(input logic [IndexW-1:0] index, input logic [TickW-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  // Writes all registers, then the two unused indexes with random data.
  task automatic apply_config(input cfg_t c);
    active_cfg = c;
    put_register(REG_LONG_PRESS_TICKS, c.long_press_ticks);
    put_register(REG_COUNT_CAP, c.count_cap);
    put_register(REG_DOUBLE_WINDOW, c.double_window);
    put_register(REG_DOUBLE_HOLD, c.double_hold);
    put_register(REG_SHORT_SERIES_GAP, c.short_series_gap);
    put_register(REG_LONG_SERIES_GAP, c.long_series_gap);
    put_register(SpareIndexLo, TickW'($urandom));
    put_register(SpareIndexHi, TickW'($urandom));
    cfg_write <= 1'b0;
  endtask

  // Mostly well-formed press and release runs, with some random noise samples and an optional pause midway.
  task automatic run_phase(input int budget, input bit pause_midway);
    int left;
    bit paused;
    left   = budget;
    paused = 1'b0;
    while (left > 0) begin
      send_run(1'b1, press_length(), left);
      send_run(1'b0, gap_length(), left);
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          if (left > 0) begin
            send_sample(1'($urandom_range(0, 1)));
            left--;
          end
        end
      end
      if (pause_midway && !paused && left < budget / 2) begin
        paused = 1'b1;
        wait_for_results();
      end
    end
  endtask

  initial begin
    int quota;
    rst       <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    pressed   <= 1'b0;
    active_cfg = make_config(LongPressTicksReset, CountCapReset, DoubleWindowReset,
                             DoubleHoldReset, ShortSeriesGapReset, LongSeriesGapReset);
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // The first short release after reset already sets the double click flag.
    quota = 100;
    send_run(1'b1, 1, quota);
    send_run(1'b0, 2, quota);
    wait_for_results();

    // Directed: close short releases, a press of exactly the threshold, a long press
    // that crosses the threshold and hits the cap, and a release past every gap.
    apply_config(make_config(3, 6, 4, 2, 0, 3));
    send_run(1'b1, 1, quota);
    send_run(1'b0, 1, quota);
    send_run(1'b1, 1, quota);
    send_run(1'b0, 1, quota);
    send_run(1'b1, 3, quota);
    send_run(1'b0, 1, quota);
    send_run(1'b1, 7, quota);
    send_run(1'b0, 6, quota);
    wait_for_results();

    // Sender idles lightly, receiver heavily; one long receiver hold-off.
    send_idle_pct = 20;
    recv_idle_pct <= 76;
    apply_config(random_config());
    hold_off_requests <= hold_off_requests + 1;
    run_phase(180, 1'b0);
    wait_for_results();
    apply_config(make_config(1, 1022, 0, 0, 0, 0));
    run_phase(150, 1'b0);
    wait_for_results();

    // Sender idles heavily, receiver lightly; one pause until all results are back.
    send_idle_pct = 76;
    recv_idle_pct <= 20;
    apply_config(random_config());
    run_phase(150, 1'b1);
    wait_for_results();
    apply_config(make_config(1, 1, 1023, 1023, 1023, 1023));
    run_phase(100, 1'b0);
    wait_for_results();

    // No idling: top settings, saturating the counters at their full width.
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    apply_config(make_config(1023, 1023, 1023, 1023, 1023, 1023));
    quota = 2000;
    send_run(1'b1, 5, quota);
    send_run(1'b0, 1030, quota);
    send_run(1'b1, 3, quota);
    send_run(1'b0, 3, quota);
    run_phase(40, 1'b0);
    wait_for_results();
    apply_config(random_config());
    hold_off_requests <= hold_off_requests + 1;
    run_phase(150, 1'b0);
    wait_for_results();

    repeat (SettleCycles) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
